>>> design/felm_pkg.sv
// Package for the FIFO eviction list manager: widths, codes, command and
// list record types shared by the front and back parts. No dependencies.
package felm_pkg;

  localparam int unsigned LINES     = 1024;
  localparam int unsigned SUBLISTS  = 32;
  localparam int unsigned MAX_SCAN  = 32;
  localparam int unsigned LINE_W    = 10;
  localparam int unsigned LINK_W    = LINE_W + 1;
  localparam int unsigned SUB_W     = 5;
  localparam int unsigned PART_W    = 3;
  localparam int unsigned LIDX_W    = PART_W + SUB_W + 1;
  localparam int unsigned SIZE_W    = 11;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned LIST_CNT  = 512;

  localparam logic [LINK_W-1:0] NIL      = '1;
  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(LINES);
  localparam logic [CNT_W-1:0]  SCAN_MAX = CNT_W'(MAX_SCAN);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 3'd0,
    OP_INSERT = 3'd1,
    OP_UNLINK = 3'd2,
    OP_CLEAN  = 3'd3,
    OP_DIRTY  = 3'd4,
    OP_SCAN   = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    K_CLEAR,
    K_INSERT,
    K_UNLINK,
    K_MOVE,
    K_SCAN,
    K_EMPTY
  } kind_e;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_OP_RD,
    ST_OP_EX,
    ST_OP_LN,
    ST_PUT_RD,
    ST_PUT_EX,
    ST_PUT_HD,
    ST_SC_LD,
    ST_SC_PICK,
    ST_SC_WAIT,
    ST_SC_END
  } state_e;

  typedef struct packed {
    kind_e               kind;
    logic [LINE_W-1:0]   line;
    logic [LIDX_W-1:0]   li_take;
    logic [LIDX_W-1:0]   li_put;
    logic [PART_W-1:0]   part;
    logic                dirty;
    logic [SUB_W-1:0]    cur0;
    logic [CNT_W-1:0]    limit;
  } cmd_t;

  typedef struct packed {
    logic [LINK_W-1:0] head;
    logic [LINK_W-1:0] tail;
    logic [SIZE_W-1:0] size;
  } lrec_t;

endpackage

>>> design/felm_front.sv
// Front part: accepts commands, classifies them and queues them for the back,
// dropping unused op codes. Depends on felm_pkg.
module felm_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic [felm_pkg::OP_W-1:0]     op_i,
  input  logic [felm_pkg::LINE_W-1:0]   line_i,
  input  logic [felm_pkg::PART_W-1:0]   partition_i,
  input  logic                          in_dirty_list_i,
  input  logic [felm_pkg::SUB_W-1:0]    start_sublist_i,
  input  logic [felm_pkg::CNT_W-1:0]    want_count_i,
  output logic                          full_o,
  output logic                          cmd_valid_o,
  output felm_pkg::cmd_t                cmd_o,
  input  logic                          cmd_pop_i
);

  felm_pkg::cmd_t          q_mem_q [2];
  logic                    wp_q, wp_d, rp_q, rp_d;
  logic [1:0]              cnt_q, cnt_d;
  felm_pkg::cmd_t          cmd_new;
  logic                    keep;
  logic [felm_pkg::SUB_W-1:0] sub;

  // classify the incoming transaction
  always_comb begin
    sub             = line_i[felm_pkg::SUB_W-1:0];
    keep            = 1'b1;
    cmd_new.kind    = felm_pkg::K_CLEAR;
    cmd_new.line    = line_i;
    cmd_new.li_take = {partition_i, sub, in_dirty_list_i};
    cmd_new.li_put  = {partition_i, sub, in_dirty_list_i};
    cmd_new.part    = partition_i;
    cmd_new.dirty   = in_dirty_list_i;
    cmd_new.cur0    = start_sublist_i - felm_pkg::SUB_W'(1);
    cmd_new.limit   = (want_count_i > felm_pkg::SCAN_MAX) ? felm_pkg::SCAN_MAX : want_count_i;
    case (felm_pkg::op_e'(op_i))
      felm_pkg::OP_CLEAR:  cmd_new.kind = felm_pkg::K_CLEAR;
      felm_pkg::OP_INSERT: cmd_new.kind = felm_pkg::K_INSERT;
      felm_pkg::OP_UNLINK: cmd_new.kind = felm_pkg::K_UNLINK;
      felm_pkg::OP_CLEAN: begin
        cmd_new.kind    = felm_pkg::K_MOVE;
        cmd_new.li_take = {partition_i, sub, 1'b1};
        cmd_new.li_put  = {partition_i, sub, 1'b0};
      end
      felm_pkg::OP_DIRTY: begin
        cmd_new.kind    = felm_pkg::K_MOVE;
        cmd_new.li_take = {partition_i, sub, 1'b0};
        cmd_new.li_put  = {partition_i, sub, 1'b1};
      end
      felm_pkg::OP_SCAN: begin
        cmd_new.kind = (want_count_i == '0) ? felm_pkg::K_EMPTY : felm_pkg::K_SCAN;
      end
      default: keep = 1'b0;
    endcase
  end

  // queue pointers
  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i && keep) begin
      wp_d  = ~wp_q;
    end
    if (cmd_pop_i) begin
      rp_d = ~rp_q;
    end
    cnt_d = cnt_q + 2'(push_i && keep) - 2'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // store queue entries
  always_ff @(posedge clk_i) begin
    if (push_i && keep) begin
      q_mem_q[wp_q] <= cmd_new;
    end
  end

  assign full_o      = cnt_q[1];
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem_q[rp_q];

endmodule

>>> design/felm_back.sv
// Back part: sequencer over the link and list memories that carries out list
// updates and scans and drives the results. Depends on felm_pkg.
module felm_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  felm_pkg::cmd_t                cmd_i,
  output logic                          cmd_pop_o,
  output logic                          clearing_o,
  output logic                          valid_o,
  output logic [felm_pkg::LINE_W-1:0]   found_line_o,
  output logic                          found_o,
  output logic                          last_o
);

  localparam int unsigned LW = felm_pkg::LINK_W;

  // memories
  logic [LW-1:0]       prev_mem [felm_pkg::LINES];
  logic [LW-1:0]       next_mem [felm_pkg::LINES];
  felm_pkg::lrec_t     list_mem [felm_pkg::LIST_CNT];
  logic [LW-1:0]       cursor_q [felm_pkg::SUBLISTS];

  logic                         pl_we, nl_we, lm_we, cw_en;
  logic [felm_pkg::LINE_W-1:0]  pl_wa, nl_wa, pl_ra, nl_ra;
  logic [LW-1:0]                pl_wd, nl_wd, pl_rd, nl_rd, cw_val;
  logic [felm_pkg::LIDX_W-1:0]  lm_wa, lm_ra;
  felm_pkg::lrec_t              lm_wd, lm_rd;
  logic [felm_pkg::SUB_W-1:0]   cw_idx;

  felm_pkg::state_e             st_q, st_d;
  felm_pkg::cmd_t               cmd_q, cmd_d;
  logic [felm_pkg::LINE_W-1:0]  clr_q, clr_d;
  logic [felm_pkg::CNT_W-1:0]   ld_q, ld_d, n_q, n_d;
  logic [felm_pkg::SUB_W-1:0]   cur_q, cur_d, nxt;
  logic [felm_pkg::SUBLISTS-1:0] live_q, live_d;
  logic                         pend_v_q, pend_v_d;
  logic [felm_pkg::LINE_W-1:0]  pend_q, pend_d;
  logic [LW-1:0]                h_q, h_d, c;
  logic                         emp_q, emp_d;
  logic                         ov_q, ov_d, of_q, of_d, ol_q, ol_d;
  logic [felm_pkg::LINE_W-1:0]  oln_q, oln_d;
  logic [LW-1:0]                ln_ext;
  logic                         at_head, at_tail, empty;

  // first live sub-list after the current one, wrapping back to itself
  function automatic logic [felm_pkg::SUB_W-1:0] next_live(
    input logic [felm_pkg::SUBLISTS-1:0] live,
    input logic [felm_pkg::SUB_W-1:0]    cur
  );
    logic [2*felm_pkg::SUBLISTS-1:0] dbl;
    logic [felm_pkg::SUBLISTS-1:0]   rot;
    logic [felm_pkg::SUB_W-1:0]      k;
    logic                            hit;
    logic [felm_pkg::SUB_W-1:0]      s;
    dbl = {live, live} >> (cur + felm_pkg::SUB_W'(1));
    rot = dbl[felm_pkg::SUBLISTS-1:0];
    k   = '0;
    hit = 1'b0;
    for (int i = 0; i < felm_pkg::SUBLISTS; i++) begin
      if (rot[i] && !hit) begin
        k   = felm_pkg::SUB_W'(i);
        hit = 1'b1;
      end
    end
    s = cur + felm_pkg::SUB_W'(1) + k;
    return s;
  endfunction

  always_ff @(posedge clk_i) begin
    if (pl_we) begin
      prev_mem[pl_wa] <= pl_wd;
    end
    pl_rd <= prev_mem[pl_ra];
  end

  always_ff @(posedge clk_i) begin
    if (nl_we) begin
      next_mem[nl_wa] <= nl_wd;
    end
    nl_rd <= next_mem[nl_ra];
  end

  always_ff @(posedge clk_i) begin
    if (lm_we) begin
      list_mem[lm_wa] <= lm_wd;
    end
    lm_rd <= list_mem[lm_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cw_en) begin
      cursor_q[cw_idx] <= cw_val;
    end
  end

  always_comb begin
    ln_ext  = {1'b0, cmd_q.line};
    at_head = (lm_rd.head == ln_ext);
    at_tail = (lm_rd.tail == ln_ext);
    empty   = (lm_rd.size == '0) || lm_rd.head[LW-1];
    nxt     = next_live(live_q, cur_q);
    c       = cursor_q[nxt];
  end

  // sequencer: next state, memory ports and results
  always_comb begin
    st_d      = st_q;
    cmd_d     = cmd_q;
    clr_d     = clr_q;
    ld_d      = ld_q;
    n_d       = n_q;
    cur_d     = cur_q;
    live_d    = live_q;
    pend_v_d  = pend_v_q;
    pend_d    = pend_q;
    h_d       = h_q;
    emp_d     = emp_q;
    ov_d      = 1'b0;
    of_d      = 1'b0;
    ol_d      = 1'b0;
    oln_d     = '0;
    cmd_pop_o = 1'b0;
    pl_we     = 1'b0;
    nl_we     = 1'b0;
    lm_we     = 1'b0;
    cw_en     = 1'b0;
    pl_wa     = cmd_q.line;
    nl_wa     = cmd_q.line;
    pl_wd     = felm_pkg::NIL;
    nl_wd     = felm_pkg::NIL;
    pl_ra     = cmd_q.line;
    nl_ra     = cmd_q.line;
    lm_ra     = cmd_q.li_take;
    lm_wa     = cmd_q.li_take;
    lm_wd     = lm_rd;
    cw_idx    = ld_q[felm_pkg::SUB_W-1:0] - felm_pkg::SUB_W'(1);
    cw_val    = lm_rd.tail;
    case (st_q)
      // sweep the link and list memories to their reset contents
      felm_pkg::ST_CLR: begin
        pl_we = 1'b1;
        nl_we = 1'b1;
        pl_wa = clr_q;
        nl_wa = clr_q;
        lm_we = !clr_q[felm_pkg::LINE_W-1];
        lm_wa = clr_q[felm_pkg::LIDX_W-1:0];
        lm_wd = '{head: felm_pkg::NIL, tail: felm_pkg::NIL, size: '0};
        clr_d = clr_q + felm_pkg::LINE_W'(1);
        if (clr_q == '1) begin
          st_d = felm_pkg::ST_IDLE;
        end
      end
      felm_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          pend_v_d  = 1'b0;
          case (cmd_i.kind)
            felm_pkg::K_CLEAR:  st_d = felm_pkg::ST_OP_LN;
            felm_pkg::K_INSERT: st_d = felm_pkg::ST_PUT_RD;
            felm_pkg::K_UNLINK: st_d = felm_pkg::ST_OP_RD;
            felm_pkg::K_MOVE:   st_d = felm_pkg::ST_OP_RD;
            felm_pkg::K_SCAN: begin
              live_d = '1;
              cur_d  = cmd_i.cur0;
              n_d    = '0;
              ld_d   = '0;
              st_d   = felm_pkg::ST_SC_LD;
            end
            default: st_d = felm_pkg::ST_SC_END;
          endcase
        end
      end
      // read the list record and the line's links
      felm_pkg::ST_OP_RD: begin
        st_d = felm_pkg::ST_OP_EX;
      end
      // unlink: update list record and neighbor links
      felm_pkg::ST_OP_EX: begin
        lm_we = 1'b1;
        if (at_head && at_tail) begin
          lm_wd.head = felm_pkg::NIL;
          lm_wd.tail = felm_pkg::NIL;
        end else if (at_head) begin
          lm_wd.head = nl_rd;
          pl_we      = !nl_rd[LW-1];
          pl_wa      = nl_rd[felm_pkg::LINE_W-1:0];
          pl_wd      = felm_pkg::NIL;
        end else if (at_tail) begin
          lm_wd.tail = pl_rd;
          nl_we      = !pl_rd[LW-1];
          nl_wa      = pl_rd[felm_pkg::LINE_W-1:0];
          nl_wd      = felm_pkg::NIL;
        end else begin
          nl_we = !pl_rd[LW-1];
          nl_wa = pl_rd[felm_pkg::LINE_W-1:0];
          nl_wd = nl_rd;
          pl_we = !nl_rd[LW-1];
          pl_wa = nl_rd[felm_pkg::LINE_W-1:0];
          pl_wd = pl_rd;
        end
        if (lm_rd.size != '0) begin
          lm_wd.size = lm_rd.size - felm_pkg::SIZE_W'(1);
        end
        st_d = felm_pkg::ST_OP_LN;
      end
      // drop the line's own links
      felm_pkg::ST_OP_LN: begin
        pl_we = 1'b1;
        nl_we = 1'b1;
        st_d  = (cmd_q.kind == felm_pkg::K_MOVE) ? felm_pkg::ST_PUT_RD : felm_pkg::ST_IDLE;
      end
      felm_pkg::ST_PUT_RD: begin
        lm_ra = cmd_q.li_put;
        st_d  = felm_pkg::ST_PUT_EX;
      end
      // insert at head: list record and the line's links
      felm_pkg::ST_PUT_EX: begin
        lm_we      = 1'b1;
        lm_wa      = cmd_q.li_put;
        lm_wd.head = ln_ext;
        pl_we      = 1'b1;
        nl_we      = 1'b1;
        if (empty) begin
          lm_wd.tail = ln_ext;
          lm_wd.size = felm_pkg::SIZE_W'(1);
          st_d       = felm_pkg::ST_IDLE;
        end else begin
          nl_wd = lm_rd.head;
          if (lm_rd.size < felm_pkg::SIZE_MAX) begin
            lm_wd.size = lm_rd.size + felm_pkg::SIZE_W'(1);
          end
          st_d = felm_pkg::ST_PUT_HD;
        end
        h_d   = lm_rd.head;
        emp_d = empty;
      end
      // link the old head back to the new one
      felm_pkg::ST_PUT_HD: begin
        pl_we = !emp_q;
        pl_wa = h_q[felm_pkg::LINE_W-1:0];
        pl_wd = ln_ext;
        st_d  = felm_pkg::ST_IDLE;
      end
      // load the scan cursors from the list tails
      felm_pkg::ST_SC_LD: begin
        lm_ra = {cmd_q.part, ld_q[felm_pkg::SUB_W-1:0], cmd_q.dirty};
        cw_en = (ld_q != '0);
        ld_d  = ld_q + felm_pkg::CNT_W'(1);
        if (ld_q == felm_pkg::CNT_W'(felm_pkg::SUBLISTS)) begin
          st_d = felm_pkg::ST_SC_PICK;
        end
      end
      // pick the next live sub-list and take its cursor
      felm_pkg::ST_SC_PICK: begin
        if (n_q == cmd_q.limit || live_q == '0) begin
          st_d = felm_pkg::ST_SC_END;
        end else begin
          cur_d = nxt;
          if (!c[LW-1]) begin
            pl_ra    = c[felm_pkg::LINE_W-1:0];
            ov_d     = pend_v_q;
            of_d     = 1'b1;
            oln_d    = pend_q;
            pend_v_d = 1'b1;
            pend_d   = c[felm_pkg::LINE_W-1:0];
            st_d     = felm_pkg::ST_SC_WAIT;
          end else begin
            live_d[nxt] = 1'b0;
          end
        end
      end
      // step the cursor backward
      felm_pkg::ST_SC_WAIT: begin
        cw_en  = 1'b1;
        cw_idx = cur_q;
        cw_val = pl_rd;
        n_d    = n_q + felm_pkg::CNT_W'(1);
        st_d   = felm_pkg::ST_SC_PICK;
      end
      // release the held line as final, or an empty result
      felm_pkg::ST_SC_END: begin
        ov_d     = 1'b1;
        of_d     = pend_v_q;
        ol_d     = 1'b1;
        oln_d    = pend_v_q ? pend_q : '0;
        pend_v_d = 1'b0;
        st_d     = felm_pkg::ST_IDLE;
      end
      default: st_d = felm_pkg::ST_IDLE;
    endcase
    if (!ov_d) begin
      of_d  = 1'b0;
      oln_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= felm_pkg::ST_CLR;
      clr_q    <= '0;
      pend_v_q <= 1'b0;
      ov_q     <= 1'b0;
      ld_q     <= '0;
      n_q      <= '0;
      live_q   <= '0;
    end else begin
      st_q     <= st_d;
      clr_q    <= clr_d;
      pend_v_q <= pend_v_d;
      ov_q     <= ov_d;
      ld_q     <= ld_d;
      n_q      <= n_d;
      live_q   <= live_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    cur_q  <= cur_d;
    pend_q <= pend_d;
    h_q    <= h_d;
    emp_q  <= emp_d;
    of_q   <= of_d;
    ol_q   <= ol_d;
    oln_q  <= oln_d;
  end

  assign clearing_o   = (st_q == felm_pkg::ST_CLR);
  assign valid_o      = ov_q;
  assign found_o      = of_q;
  assign last_o       = ol_q;
  assign found_line_o = oln_q;

endmodule

>>> design/fifo_eviction_list_manager_top.sv
// Top level of the FIFO eviction list manager: front command queue and back
// sequencer. Depends on felm_pkg, felm_front and felm_back.
//
// Commands are taken when start is high and busy is low; results appear
// for one cycle with valid_o and cannot be held off. After reset the block
// sweeps its link and list memories with busy high. Once the back picks up
// a command, a clear drops the line's links; an insert writes the record
// and links, then links an old head back; an unlink updates the record and
// neighbour links, then drops the line's; a move unlinks, then inserts. A
// scan loads its 32 cursors from the tail memory, takes lines from the live
// sub-lists in turn and ends with a final result. All of it is bounded by
// the link and list memories, each with one read and one write port. Two
// queue entries buffer commands; busy also rises when both are waiting.
module fifo_eviction_list_manager_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [felm_pkg::OP_W-1:0]     op_i,
  input  logic [felm_pkg::LINE_W-1:0]   line_i,
  input  logic [felm_pkg::PART_W-1:0]   partition_i,
  input  logic                          in_dirty_list_i,
  input  logic [felm_pkg::SUB_W-1:0]    start_sublist_i,
  input  logic [felm_pkg::CNT_W-1:0]    want_count_i,
  output logic                          valid_o,
  output logic [felm_pkg::LINE_W-1:0]   found_line_o,
  output logic                          found_o,
  output logic                          last_o
);

  logic           full, clearing, cmd_valid, cmd_pop;
  felm_pkg::cmd_t cmd;

  assign busy = full | clearing;

  felm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (start && !busy),
    .op_i            (op_i),
    .line_i          (line_i),
    .partition_i     (partition_i),
    .in_dirty_list_i (in_dirty_list_i),
    .start_sublist_i (start_sublist_i),
    .want_count_i    (want_count_i),
    .full_o          (full),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_pop_i       (cmd_pop)
  );

  felm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .clearing_o   (clearing),
    .valid_o      (valid_o),
    .found_line_o (found_line_o),
    .found_o      (found_o),
    .last_o       (last_o)
  );

`ifndef SYNTHESIS
  // an empty scan result is always the final one
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !found_o) |-> last_o) else $error("empty result not last");
  // nothing is strobed without valid
  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> (!found_o && !last_o && found_line_o == '0))
    else $error("result fields active without valid");
  // no command is taken during the memory sweep
  a_sweep_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> busy) else $error("not busy during memory sweep");
  // the back never pops an empty queue
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid) else $error("pop from empty queue");
`endif

endmodule

>>> bench/fifo_eviction_list_manager_top_tb.sv
// Testbench for fifo_eviction_list_manager_top: predicts the linked-list state and
// the scan output, then checks every result against it. Depends on felm_pkg.
module fifo_eviction_list_manager_top_tb;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [felm_pkg::LINE_W-1:0] line;
    logic                        found;
    logic                        last;
  } scan_hit_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start;
  logic                          busy;
  logic [felm_pkg::OP_W-1:0]     op_i;
  logic [felm_pkg::LINE_W-1:0]   line_i;
  logic [felm_pkg::PART_W-1:0]   partition_i;
  logic                          in_dirty_list_i;
  logic [felm_pkg::SUB_W-1:0]    start_sublist_i;
  logic [felm_pkg::CNT_W-1:0]    want_count_i;
  logic                          valid_o;
  logic [felm_pkg::LINE_W-1:0]   found_line_o;
  logic                          found_o;
  logic                          last_o;

  // Mirror of the link and list memories
  logic [felm_pkg::LINK_W-1:0] prev_q [felm_pkg::LINES];
  logic [felm_pkg::LINK_W-1:0] next_q [felm_pkg::LINES];
  logic [felm_pkg::LINK_W-1:0] head_q [felm_pkg::LIST_CNT];
  logic [felm_pkg::LINK_W-1:0] tail_q [felm_pkg::LIST_CNT];
  logic [felm_pkg::SIZE_W-1:0] size_q [felm_pkg::LIST_CNT];

  // Where the stimulus thinks each line sits: 0 none, 1 clean, 2 dirty
  int unsigned                 where_kind [felm_pkg::LINES];
  logic [felm_pkg::PART_W-1:0] where_part [felm_pkg::LINES];

  scan_hit_t   scan_hits_q [$];
  int unsigned n_errors;
  int unsigned n_cycles;
  bit          idle_en;

  fifo_eviction_list_manager_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .op_i            (op_i),
    .line_i          (line_i),
    .partition_i     (partition_i),
    .in_dirty_list_i (in_dirty_list_i),
    .start_sublist_i (start_sublist_i),
    .want_count_i    (want_count_i),
    .valid_o         (valid_o),
    .found_line_o    (found_line_o),
    .found_o         (found_o),
    .last_o          (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Bound the run
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  function automatic logic [felm_pkg::LIDX_W-1:0] list_idx(
    input logic [felm_pkg::PART_W-1:0] part,
    input logic [felm_pkg::SUB_W-1:0]  sub,
    input logic                        dirty
  );
    return {part, sub, dirty};
  endfunction

  function automatic bit is_line(input logic [felm_pkg::LINK_W-1:0] v);
    return v < felm_pkg::LINES;
  endfunction

  function automatic void push_head(input logic [felm_pkg::LIDX_W-1:0] li,
                                    input logic [felm_pkg::LINE_W-1:0] ln);
    logic [felm_pkg::LINK_W-1:0] h;
    h = head_q[li];
    if (size_q[li] == '0 || !is_line(h)) begin
      head_q[li] = {1'b0, ln};
      tail_q[li] = {1'b0, ln};
      next_q[ln] = felm_pkg::NIL;
      prev_q[ln] = felm_pkg::NIL;
      size_q[li] = felm_pkg::SIZE_W'(1);
    end else begin
      next_q[ln] = h;
      prev_q[ln] = felm_pkg::NIL;
      prev_q[h[felm_pkg::LINE_W-1:0]] = {1'b0, ln};
      head_q[li] = {1'b0, ln};
      if (size_q[li] < felm_pkg::SIZE_MAX) size_q[li] = size_q[li] + felm_pkg::SIZE_W'(1);
    end
  endfunction

  function automatic void unlink_line(input logic [felm_pkg::LIDX_W-1:0] li,
                                      input logic [felm_pkg::LINE_W-1:0] ln);
    bit                          at_head;
    bit                          at_tail;
    logic [felm_pkg::LINK_W-1:0] nx;
    logic [felm_pkg::LINK_W-1:0] pv;
    at_head = head_q[li] == {1'b0, ln};
    at_tail = tail_q[li] == {1'b0, ln};
    nx = next_q[ln];
    pv = prev_q[ln];
    if (at_head && at_tail) begin
      head_q[li] = felm_pkg::NIL;
      tail_q[li] = felm_pkg::NIL;
    end else if (at_head) begin
      head_q[li] = nx;
      if (is_line(nx)) prev_q[nx[felm_pkg::LINE_W-1:0]] = felm_pkg::NIL;
    end else if (at_tail) begin
      tail_q[li] = pv;
      if (is_line(pv)) next_q[pv[felm_pkg::LINE_W-1:0]] = felm_pkg::NIL;
    end else begin
      if (is_line(pv)) next_q[pv[felm_pkg::LINE_W-1:0]] = nx;
      if (is_line(nx)) prev_q[nx[felm_pkg::LINE_W-1:0]] = pv;
    end
    next_q[ln] = felm_pkg::NIL;
    prev_q[ln] = felm_pkg::NIL;
    if (size_q[li] > '0) size_q[li] = size_q[li] - felm_pkg::SIZE_W'(1);
  endfunction

  // Walk the tails round robin and queue the lines a scan must return
  function automatic void predict_scan(input logic [felm_pkg::PART_W-1:0] part,
                                       input logic dirty,
                                       input logic [felm_pkg::SUB_W-1:0] first,
                                       input int unsigned want);
    logic [felm_pkg::LINK_W-1:0] cursor [felm_pkg::SUBLISTS];
    logic [31:0]                 live;
    logic [felm_pkg::LINK_W-1:0] c;
    int unsigned                 lim;
    int unsigned                 cur;
    int unsigned                 inc;
    int unsigned                 r;
    int unsigned                 n;
    scan_hit_t                   hit;
    n = 0;
    if (want != 0) begin
      lim = (want > felm_pkg::MAX_SCAN) ? felm_pkg::MAX_SCAN : want;
      cur = (first + felm_pkg::SUBLISTS - 1) % felm_pkg::SUBLISTS;
      live = '1;
      for (int i = 0; i < felm_pkg::SUBLISTS; i++)
        cursor[i] = tail_q[list_idx(part, felm_pkg::SUB_W'(i), dirty)];
      while (n < lim && live != 0) begin
        inc = 0;
        for (int i = felm_pkg::SUBLISTS - 1; i >= 0; i--) if (live[i]) inc = i + 1;
        r = inc % felm_pkg::SUBLISTS;
        if (r != 0) live = (live >> r) | (live << (felm_pkg::SUBLISTS - r));
        cur = (cur + inc) % felm_pkg::SUBLISTS;
        c = cursor[cur];
        if (is_line(c)) begin
          cursor[cur] = prev_q[c[felm_pkg::LINE_W-1:0]];
          hit.line = c[felm_pkg::LINE_W-1:0];
          hit.found = 1'b1;
          hit.last = 1'b0;
          scan_hits_q.push_back(hit);
          n++;
        end else begin
          live[felm_pkg::SUBLISTS-1] = 1'b0;
        end
      end
    end
    if (n == 0) begin
      hit.line = '0;
      hit.found = 1'b0;
      hit.last = 1'b0;
      scan_hits_q.push_back(hit);
    end
    scan_hits_q[scan_hits_q.size()-1].last = 1'b1;
  endfunction

  // Apply one accepted transaction to the mirror
  function automatic void predict_op(input logic [felm_pkg::OP_W-1:0] op,
                                     input logic [felm_pkg::LINE_W-1:0] ln,
                                     input logic [felm_pkg::PART_W-1:0] part,
                                     input logic dirty,
                                     input logic [felm_pkg::SUB_W-1:0] first,
                                     input logic [felm_pkg::CNT_W-1:0] want);
    logic [felm_pkg::SUB_W-1:0] sub;
    sub = ln[felm_pkg::SUB_W-1:0];
    case (op)
      felm_pkg::OP_CLEAR: begin
        prev_q[ln] = felm_pkg::NIL;
        next_q[ln] = felm_pkg::NIL;
      end
      felm_pkg::OP_INSERT: push_head(list_idx(part, sub, dirty), ln);
      felm_pkg::OP_UNLINK: unlink_line(list_idx(part, sub, dirty), ln);
      felm_pkg::OP_CLEAN: begin
        unlink_line(list_idx(part, sub, 1'b1), ln);
        push_head(list_idx(part, sub, 1'b0), ln);
      end
      felm_pkg::OP_DIRTY: begin
        unlink_line(list_idx(part, sub, 1'b0), ln);
        push_head(list_idx(part, sub, 1'b1), ln);
      end
      felm_pkg::OP_SCAN: predict_scan(part, dirty, first, want);
      default: ;
    endcase
  endfunction

  // Send one transaction, predict it once accepted, then maybe idle
  task automatic send_cmd(input logic [felm_pkg::OP_W-1:0] op,
                          input logic [felm_pkg::LINE_W-1:0] ln,
                          input logic [felm_pkg::PART_W-1:0] part,
                          input logic dirty,
                          input logic [felm_pkg::SUB_W-1:0] first,
                          input logic [felm_pkg::CNT_W-1:0] want);
    @(negedge clk_i);
    op_i = op;
    line_i = ln;
    partition_i = part;
    in_dirty_list_i = dirty;
    start_sublist_i = first;
    want_count_i = want;
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    predict_op(op, ln, part, dirty, first, want);
    case (op)
      felm_pkg::OP_INSERT: begin
        where_kind[ln] = dirty ? 2 : 1;
        where_part[ln] = part;
      end
      felm_pkg::OP_UNLINK: where_kind[ln] = 0;
      felm_pkg::OP_CLEAN:  begin where_kind[ln] = 1; where_part[ln] = part; end
      felm_pkg::OP_DIRTY:  begin where_kind[ln] = 2; where_part[ln] = part; end
      default: ;
    endcase
    if (idle_en && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat ($urandom_range(0, 15)) @(negedge clk_i);
    end
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (scan_hits_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result line=%0d found=%0b last=%0b",
                                  found_line_o, found_o, last_o));
      end else begin
        scan_hit_t e;
        e = scan_hits_q.pop_front();
        if (found_line_o !== e.line)
          report_mismatch($sformatf("found_line %0d, want %0d", found_line_o, e.line));
        if (found_o !== e.found)
          report_mismatch($sformatf("found %0b, want %0b", found_o, e.found));
        if (last_o !== e.last)
          report_mismatch($sformatf("last %0b, want %0b", last_o, e.last));
      end
    end
  end

  function automatic logic [felm_pkg::LINE_W-1:0] pool_line();
    return ($urandom_range(0, 9) < 7) ?
           felm_pkg::LINE_W'($urandom_range(0, 127)) :
           felm_pkg::LINE_W'($urandom_range(0, felm_pkg::LINES - 1));
  endfunction

  function automatic logic [felm_pkg::PART_W-1:0] pool_part();
    return ($urandom_range(0, 9) < 7) ? felm_pkg::PART_W'($urandom_range(0, 1)) :
                                        felm_pkg::PART_W'($urandom);
  endfunction

  // Find a line in some list, or report none after a few tries
  function automatic bit pick_member(output logic [felm_pkg::LINE_W-1:0] ln);
    for (int t = 0; t < 40; t++) begin
      ln = pool_line();
      if (where_kind[ln] != 0) return 1'b1;
    end
    return 1'b0;
  endfunction

  // One random transaction: mostly consistent list use, some noise
  task automatic send_random();
    logic [felm_pkg::LINE_W-1:0] ln;
    int unsigned                 sel;
    if ($urandom_range(0, 99) < 15) begin
      send_cmd(felm_pkg::OP_W'($urandom), felm_pkg::LINE_W'($urandom),
               felm_pkg::PART_W'($urandom), 1'($urandom),
               felm_pkg::SUB_W'($urandom), felm_pkg::CNT_W'($urandom));
      return;
    end
    sel = $urandom_range(0, 99);
    if (sel >= 35 && sel < 75 && pick_member(ln)) begin
      if (sel < 55)
        send_cmd(felm_pkg::OP_UNLINK, ln, where_part[ln], where_kind[ln] == 2,
                 felm_pkg::SUB_W'($urandom), felm_pkg::CNT_W'($urandom));
      else if (where_kind[ln] == 2)
        send_cmd(felm_pkg::OP_CLEAN, ln, where_part[ln], 1'($urandom),
                 felm_pkg::SUB_W'($urandom), felm_pkg::CNT_W'($urandom));
      else
        send_cmd(felm_pkg::OP_DIRTY, ln, where_part[ln], 1'($urandom),
                 felm_pkg::SUB_W'($urandom), felm_pkg::CNT_W'($urandom));
    end else if (sel >= 75 && sel < 95) begin
      send_cmd(felm_pkg::OP_SCAN, felm_pkg::LINE_W'($urandom), pool_part(), 1'($urandom),
               felm_pkg::SUB_W'($urandom),
               felm_pkg::CNT_W'($urandom_range(1, felm_pkg::MAX_SCAN)));
    end else begin
      ln = pool_line();
      if (where_kind[ln] != 0 || sel >= 95)
        send_cmd(felm_pkg::OP_CLEAR, ln, felm_pkg::PART_W'($urandom), 1'($urandom),
                 felm_pkg::SUB_W'($urandom), felm_pkg::CNT_W'($urandom));
      else
        send_cmd(felm_pkg::OP_INSERT, ln, pool_part(), 1'($urandom),
                 felm_pkg::SUB_W'($urandom), felm_pkg::CNT_W'($urandom));
    end
  endtask

  // Head, tail, only-node and middle unlinks, moves, scan limits, unused codes
  task automatic test_directed();
    send_cmd(felm_pkg::OP_SCAN, '0, 3'd0, 1'b0, 5'd0, 6'd32);
    send_cmd(felm_pkg::OP_INSERT, 10'd0, 3'd0, 1'b0, '0, '0);
    send_cmd(felm_pkg::OP_INSERT, 10'd32, 3'd0, 1'b0, '0, '0);
    send_cmd(felm_pkg::OP_INSERT, 10'd64, 3'd0, 1'b0, '0, '0);
    send_cmd(felm_pkg::OP_INSERT, 10'd33, 3'd0, 1'b0, '0, '0);
    send_cmd(felm_pkg::OP_SCAN, '0, 3'd0, 1'b0, 5'd31, 6'd32);
    send_cmd(felm_pkg::OP_UNLINK, 10'd32, 3'd0, 1'b0, '0, '0);
    send_cmd(felm_pkg::OP_UNLINK, 10'd64, 3'd0, 1'b0, '0, '0);
    send_cmd(felm_pkg::OP_UNLINK, 10'd0, 3'd0, 1'b0, '0, '0);
    send_cmd(felm_pkg::OP_UNLINK, 10'd33, 3'd0, 1'b0, '0, '0);
    send_cmd(felm_pkg::OP_INSERT, 10'd1023, 3'd7, 1'b1, '0, '0);
    send_cmd(felm_pkg::OP_INSERT, 10'd991, 3'd7, 1'b1, '0, '0);
    send_cmd(felm_pkg::OP_INSERT, 10'd1, 3'd7, 1'b1, '0, '0);
    send_cmd(felm_pkg::OP_CLEAN, 10'd1023, 3'd7, 1'b1, '0, '0);
    send_cmd(felm_pkg::OP_SCAN, '1, 3'd7, 1'b1, 5'd31, 6'd63);
    send_cmd(felm_pkg::OP_DIRTY, 10'd1023, 3'd7, 1'b0, '0, '0);
    send_cmd(felm_pkg::OP_SCAN, '0, 3'd7, 1'b1, 5'd0, 6'd1);
    send_cmd(felm_pkg::OP_SCAN, '0, 3'd7, 1'b1, 5'd0, 6'd0);
    send_cmd(felm_pkg::OP_SCAN, '0, 3'd7, 1'b1, 5'd1, 6'd33);
    send_cmd(felm_pkg::OP_CLEAR, 10'd5, 3'd0, 1'b0, '0, '0);
    send_cmd(felm_pkg::OP_W'(6), 10'd1, 3'd7, 1'b1, 5'd3, 6'd4);
    send_cmd(felm_pkg::OP_W'(7), 10'd1, 3'd7, 1'b1, 5'd3, 6'd4);
    send_cmd(felm_pkg::OP_SCAN, '0, 3'd7, 1'b0, 5'd4, 6'd32);
  endtask

  task automatic test_random(input int unsigned n);
    repeat (n) send_random();
  endtask

  // Hold off until every expected result has come, then resume
  task automatic test_drain_pause();
    @(negedge clk_i);
    start = 1'b0;
    wait (scan_hits_q.size() == 0);
    test_random(15);
  endtask

  task automatic test_tail_no_idle();
    idle_en = 1'b0;
    test_random(30);
  endtask

  initial begin
    n_errors = 0;
    n_cycles = 0;
    idle_en = 1'b1;
    start = 1'b0;
    op_i = '0;
    line_i = '0;
    partition_i = '0;
    in_dirty_list_i = 1'b0;
    start_sublist_i = '0;
    want_count_i = '0;
    for (int i = 0; i < felm_pkg::LINES; i++) begin
      prev_q[i] = felm_pkg::NIL;
      next_q[i] = felm_pkg::NIL;
      where_kind[i] = 0;
      where_part[i] = '0;
    end
    for (int i = 0; i < felm_pkg::LIST_CNT; i++) begin
      head_q[i] = felm_pkg::NIL;
      tail_q[i] = felm_pkg::NIL;
      size_q[i] = '0;
    end
    rst_ni = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random(110);
    test_drain_pause();
    test_tail_no_idle();

    @(negedge clk_i);
    start = 1'b0;
    wait (scan_hits_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
design/felm_pkg.sv
design/felm_front.sv
design/felm_back.sv
design/fifo_eviction_list_manager_top.sv
bench/fifo_eviction_list_manager_top_tb.sv
